FILE: design/mep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, codes and control types of the midpoint ellipse point
// generator.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int COORD_BITS = 11;
  localparam int OUT_BITS   = COORD_BITS + 1;
  localparam int OFF_BITS   = COORD_BITS;
  localparam int RAD_BITS   = 10;
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int SLOPE_BITS = 32;
  localparam int DEC_BITS   = 46;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 4;

  localparam int A_BITS     = OFF_BITS + 1;
  localparam int MUL_A_BITS = (SQ_BITS > A_BITS) ? SQ_BITS : A_BITS;
  localparam int MUL_B_BITS = (2 * A_BITS > SQ_BITS) ? 2 * A_BITS : SQ_BITS;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS_X = 2'd2,
    REG_RADIUS_Y = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_INIT,
    ST_INIT,
    ST_STEP,
    ST_SW_AA,
    ST_SW_T1,
    ST_SW_BB,
    ST_SW_T2,
    ST_SW_T3,
    ST_SW_DEC
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MUL_RX2_RY,
    MUL_AA,
    MUL_RY2_SQ,
    MUL_BB,
    MUL_RX2_SQ,
    MUL_RX2_RY2
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_init;
    logic     acc_load;
    logic     acc_add;
    logic     dec_switch;
    logic     step;
  } mep_cmd_t;

  typedef struct packed {
    logic active;
    logic need_switch;
  } mep_stat_t;

endpackage
`default_nettype wire

FILE: design/mep_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_regs
// Configuration registers on the bus port, plus registered squares of radii.
// ----------------------------------------------------------------------------
module mep_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mep_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [mep_pkg::DATA_BITS-1:0]      pwdata,
  output logic      [mep_pkg::DATA_BITS-1:0]      prdata,
  output logic                                    pready,
  output logic      [mep_pkg::COORD_BITS-1:0]     center_x,
  output logic      [mep_pkg::COORD_BITS-1:0]     center_y,
  output logic      [mep_pkg::RAD_BITS-1:0]       radius_y,
  output logic      [mep_pkg::SQ_BITS-1:0]        radius_x_sq,
  output logic      [mep_pkg::SQ_BITS-1:0]        radius_y_sq
);
  import mep_pkg::*;

  logic [COORD_BITS-1:0] cx_r;
  logic [COORD_BITS-1:0] cy_r;
  logic [RAD_BITS-1:0]   rx_r;
  logic [RAD_BITS-1:0]   ry_r;
  logic [SQ_BITS-1:0]    rx2_r;
  logic [SQ_BITS-1:0]    ry2_r;
  logic                  wr_en;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rx_r  <= '0;
      ry_r  <= '0;
      rx2_r <= '0;
      ry2_r <= '0;
    end else begin
      rx2_r <= SQ_BITS'(rx_r * rx_r);
      ry2_r <= SQ_BITS'(ry_r * ry_r);
      if (wr_en) begin
        unique case (idx)
          REG_CENTER_X: cx_r <= pwdata[COORD_BITS-1:0];
          REG_CENTER_Y: cy_r <= pwdata[COORD_BITS-1:0];
          REG_RADIUS_X: rx_r <= pwdata[RAD_BITS-1:0];
          REG_RADIUS_Y: ry_r <= pwdata[RAD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X: prdata = {{(DATA_BITS-COORD_BITS){cx_r[COORD_BITS-1]}}, cx_r};
      REG_CENTER_Y: prdata = {{(DATA_BITS-COORD_BITS){cy_r[COORD_BITS-1]}}, cy_r};
      REG_RADIUS_X: prdata = DATA_BITS'(rx_r);
      REG_RADIUS_Y: prdata = DATA_BITS'(ry_r);
      default:      prdata = '0;
    endcase
  end

  assign center_x    = cx_r;
  assign center_y    = cy_r;
  assign radius_y    = ry_r;
  assign radius_x_sq = rx2_r;
  assign radius_y_sq = ry2_r;

endmodule
`default_nettype wire

FILE: design/mep_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_ctrl
// Sequencer: item handshake, restart and region-switch multiply sequences,
// result valid.
// ----------------------------------------------------------------------------
module mep_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_restart,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire mep_pkg::mep_stat_t stat,
  output mep_pkg::mep_cmd_t      cmd
);
  import mep_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_acc;
  logic        out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_restart)       state_nxt = ST_MUL_INIT;
          else if (stat.active) state_nxt = ST_STEP;
        end
      end
      ST_MUL_INIT: state_nxt = ST_INIT;
      ST_INIT:     state_nxt = ST_STEP;
      ST_STEP: begin
        if (stat.need_switch) state_nxt = ST_SW_AA;
        else if (out_free)    state_nxt = ST_IDLE;
      end
      ST_SW_AA:  state_nxt = ST_SW_T1;
      ST_SW_T1:  state_nxt = ST_SW_BB;
      ST_SW_BB:  state_nxt = ST_SW_T2;
      ST_SW_T2:  state_nxt = ST_SW_T3;
      ST_SW_T3:  state_nxt = ST_SW_DEC;
      ST_SW_DEC: state_nxt = ST_STEP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{mul_en: 1'b0, mul_sel: MUL_RX2_RY, load_init: 1'b0, acc_load: 1'b0,
            acc_add: 1'b0, dec_switch: 1'b0, step: 1'b0};
    unique case (state_r)
      ST_MUL_INIT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_RY;
      end
      ST_INIT: cmd.load_init = 1'b1;
      ST_STEP: cmd.step = ~stat.need_switch & out_free;
      ST_SW_AA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA;
      end
      ST_SW_T1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RY2_SQ;
      end
      ST_SW_BB: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_BB;
      end
      ST_SW_T2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_SQ;
      end
      ST_SW_T3: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_RY2;
      end
      ST_SW_DEC: cmd.dec_switch = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.step)        out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: design/mep_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_dp
// Datapath: offsets, slope terms, decision, shared multiplier and result
// register.
// ----------------------------------------------------------------------------
module mep_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mep_pkg::mep_cmd_t                  cmd,
  output mep_pkg::mep_stat_t                      stat,
  input  wire logic [mep_pkg::COORD_BITS-1:0]     center_x,
  input  wire logic [mep_pkg::COORD_BITS-1:0]     center_y,
  input  wire logic [mep_pkg::RAD_BITS-1:0]       radius_y,
  input  wire logic [mep_pkg::SQ_BITS-1:0]        radius_x_sq,
  input  wire logic [mep_pkg::SQ_BITS-1:0]        radius_y_sq,
  output logic      [mep_pkg::OUT_BITS-1:0]       x_plus,
  output logic      [mep_pkg::OUT_BITS-1:0]       x_minus,
  output logic      [mep_pkg::OUT_BITS-1:0]       y_plus,
  output logic      [mep_pkg::OUT_BITS-1:0]       y_minus,
  output logic                                    region,
  output logic                                    last_point
);
  import mep_pkg::*;

  logic [OFF_BITS-1:0]   ox_r, ox_nxt;
  logic [OFF_BITS-1:0]   oy_r, oy_nxt;
  logic [SLOPE_BITS-1:0] sx_r, sx_nxt;
  logic [SLOPE_BITS-1:0] sy_r, sy_nxt;
  logic [DEC_BITS-1:0]   dec_r, dec_nxt;
  logic                  reg2_r;
  logic                  active_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic [DEC_BITS-1:0]   acc_r;
  logic [OUT_BITS-1:0]   xp_r, xm_r, yp_r, ym_r;
  logic                  region_r, last_r;

  logic [SLOPE_BITS-1:0] sx_inc, sy_dec;
  logic [DEC_BITS-1:0]   sx_e, sy_e, rx2_e, ry2_e, prod_e;
  logic                  dec_neg, dec_zero, is_last;
  logic [OUT_BITS-1:0]   cx_e, cy_e, ox_e, oy_e;
  logic [A_BITS-1:0]     a_val, b_val;
  logic [OFF_BITS-1:0]   b_abs;
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;

  assign sx_inc   = sx_r + SLOPE_BITS'({radius_y_sq, 1'b0});
  assign sy_dec   = sy_r - SLOPE_BITS'({radius_x_sq, 1'b0});
  assign sx_e     = DEC_BITS'(sx_inc);
  assign sy_e     = DEC_BITS'(sy_dec);
  assign rx2_e    = DEC_BITS'(radius_x_sq);
  assign ry2_e    = DEC_BITS'(radius_y_sq);
  assign prod_e   = DEC_BITS'(prod_r);
  assign dec_neg  = dec_r[DEC_BITS-1];
  assign dec_zero = (dec_r == '0);
  assign is_last  = reg2_r & (oy_r == '0);

  assign stat.active      = active_r;
  assign stat.need_switch = ~reg2_r & ~(sx_r < sy_r);

  assign cx_e = {center_x[COORD_BITS-1], center_x};
  assign cy_e = {center_y[COORD_BITS-1], center_y};
  assign ox_e = OUT_BITS'(ox_r);
  assign oy_e = OUT_BITS'({oy_r[OFF_BITS-1], oy_r});

  // region-two start terms: a = 2x+1, b = y-1
  assign a_val = {ox_r, 1'b1};
  assign b_val = {oy_r[OFF_BITS-1], oy_r} - A_BITS'(1);
  assign b_abs = b_val[A_BITS-1] ? OFF_BITS'(-b_val) : OFF_BITS'(b_val);

  always_comb begin
    case (cmd.mul_sel)
      MUL_RX2_RY: begin
        mul_a = MUL_A_BITS'(radius_x_sq);
        mul_b = MUL_B_BITS'(radius_y);
      end
      MUL_AA: begin
        mul_a = MUL_A_BITS'(a_val);
        mul_b = MUL_B_BITS'(a_val);
      end
      MUL_RY2_SQ: begin
        mul_a = MUL_A_BITS'(radius_y_sq);
        mul_b = prod_r[MUL_B_BITS-1:0];
      end
      MUL_BB: begin
        mul_a = MUL_A_BITS'(b_abs);
        mul_b = MUL_B_BITS'(b_abs);
      end
      MUL_RX2_SQ: begin
        mul_a = MUL_A_BITS'(radius_x_sq);
        mul_b = prod_r[MUL_B_BITS-1:0];
      end
      MUL_RX2_RY2: begin
        mul_a = MUL_A_BITS'(radius_x_sq);
        mul_b = MUL_B_BITS'(radius_y_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ox_nxt  = ox_r;
    oy_nxt  = oy_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    dec_nxt = dec_r;
    if (!reg2_r) begin
      ox_nxt = ox_r + OFF_BITS'(1);
      sx_nxt = sx_inc;
      if (dec_neg) begin
        dec_nxt = dec_r + ((sx_e + ry2_e) << 2);
      end else begin
        oy_nxt  = oy_r - OFF_BITS'(1);
        sy_nxt  = sy_dec;
        dec_nxt = dec_r + ((sx_e - sy_e + ry2_e) << 2);
      end
    end else begin
      oy_nxt = oy_r - OFF_BITS'(1);
      sy_nxt = sy_dec;
      if (!dec_neg && !dec_zero) begin
        dec_nxt = dec_r + ((rx2_e - sy_e) << 2);
      end else begin
        ox_nxt  = ox_r + OFF_BITS'(1);
        sx_nxt  = sx_inc;
        dec_nxt = dec_r + ((sx_e - sy_e + rx2_e) << 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      reg2_r   <= 1'b0;
    end else if (cmd.load_init) begin
      active_r <= 1'b1;
      reg2_r   <= 1'b0;
    end else if (cmd.dec_switch) begin
      reg2_r <= 1'b1;
    end else if (cmd.step && is_last) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en)   prod_r <= PROD_BITS'(mul_a * mul_b);
    if (cmd.acc_load) acc_r  <= prod_e;
    else if (cmd.acc_add) acc_r <= acc_r + (prod_e << 2);
    if (cmd.load_init) begin
      ox_r  <= '0;
      oy_r  <= OFF_BITS'(radius_y);
      sx_r  <= '0;
      sy_r  <= SLOPE_BITS'({prod_r, 1'b0});
      dec_r <= (ry2_e << 2) - (prod_e << 2) + rx2_e;
    end else if (cmd.dec_switch) begin
      dec_r <= acc_r - (prod_e << 2);
    end else if (cmd.step) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      dec_r <= dec_nxt;
    end
    if (cmd.step) begin
      xp_r     <= cx_e + ox_e;
      xm_r     <= cx_e - ox_e;
      yp_r     <= cy_e + oy_e;
      ym_r     <= cy_e - oy_e;
      region_r <= reg2_r;
      last_r   <= is_last;
    end
  end

  assign x_plus     = xp_r;
  assign x_minus    = xm_r;
  assign y_plus     = yp_r;
  assign y_minus    = ym_r;
  assign region     = region_r;
  assign last_point = last_r;

endmodule
`default_nettype wire

FILE: design/midpoint_ellipse_points.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_points
// Midpoint outline generator for an axis-aligned ellipse: one item yields the
// four symmetric points of one iteration.
// ----------------------------------------------------------------------------
//  channel | ports                                | payload
//  --------+--------------------------------------+-------------------------
//  in      | in_valid, in_stall                   | in_restart
//  out     | out_valid, out_stall                 | out_x_plus, out_x_minus,
//          |                                      | out_y_plus, out_y_minus,
//          |                                      | out_region, out_last_point
//  cfg     | psel, penable, pwrite, pready        | paddr, pwdata, prdata
//
// An advance is accepted, then takes one step of the adders.
// A restart adds one pass of the shared multiplier and the load.
// Entering region two adds the check, five products on the shared
// multiplier and the decision load.
// An advance with no active outline gives no item.
// The result register holds while out_stall is high; the next step waits.
// Reset (synchronous) clears the control and configuration registers; the block idles until a restart.
// ----------------------------------------------------------------------------
module midpoint_ellipse_points (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_restart,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [mep_pkg::OUT_BITS-1:0]       out_x_plus,
  output logic signed [mep_pkg::OUT_BITS-1:0]       out_x_minus,
  output logic signed [mep_pkg::OUT_BITS-1:0]       out_y_plus,
  output logic signed [mep_pkg::OUT_BITS-1:0]       out_y_minus,
  output logic                                      out_region,
  output logic                                      out_last_point,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mep_pkg::ADDR_BITS-1:0]        paddr,
  input  wire logic [mep_pkg::DATA_BITS-1:0]        pwdata,
  output logic      [mep_pkg::DATA_BITS-1:0]        prdata,
  output logic                                      pready
);
  import mep_pkg::*;

  logic [COORD_BITS-1:0] center_x, center_y;
  logic [RAD_BITS-1:0]   radius_y;
  logic [SQ_BITS-1:0]    radius_x_sq, radius_y_sq;
  logic [OUT_BITS-1:0]   x_plus, x_minus, y_plus, y_minus;
  mep_cmd_t              cmd;
  mep_stat_t             stat;

  mep_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_y    (radius_y),
    .radius_x_sq (radius_x_sq),
    .radius_y_sq (radius_y_sq)
  );

  mep_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  mep_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_y    (radius_y),
    .radius_x_sq (radius_x_sq),
    .radius_y_sq (radius_y_sq),
    .x_plus      (x_plus),
    .x_minus     (x_minus),
    .y_plus      (y_plus),
    .y_minus     (y_minus),
    .region      (out_region),
    .last_point  (out_last_point)
  );

  assign out_x_plus  = x_plus;
  assign out_x_minus = x_minus;
  assign out_y_plus  = y_plus;
  assign out_y_minus = y_minus;

endmodule
`default_nettype wire

FILE: sim/tb_midpoint_ellipse_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_ellipse_points
// Drives restart and advance items into the ellipse outline generator while
// an in-house copy of the midpoint recurrences predicts every point item. It
// covers idle advances, zero radii, restarts and center changes mid-outline,
// extreme centers and radii, and random outlines under random stalls on both
// channels, including one long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_points;
  import mep_pkg::*;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x_plus;
    logic signed [OUT_BITS-1:0] x_minus;
    logic signed [OUT_BITS-1:0] y_plus;
    logic signed [OUT_BITS-1:0] y_minus;
    logic                       region;
    logic                       last_point;
  } point_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_BITS-1:0] out_x_plus, out_x_minus, out_y_plus, out_y_minus;
  logic out_region, out_last_point;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  logic signed [COORD_BITS-1:0] cfg_cx = '0, cfg_cy = '0;
  logic [RAD_BITS-1:0]          cfg_rx = '0, cfg_ry = '0;
  logic [OFF_BITS-1:0]          ell_x = '0;
  logic signed [OFF_BITS-1:0]   ell_y = '0;
  logic [SLOPE_BITS-1:0]        ell_sx = '0, ell_sy = '0;
  logic [DEC_BITS-1:0]          ell_dec = '0;
  logic                         ell_r2 = 1'b0, ell_active = 1'b0;

  logic   step_items[$];
  point_t expected_points[$];
  int     points_made = 0;
  int     mismatches = 0;
  int     send_gap_pct = 0, recv_gap_pct = 0;
  int     holds_asked = 0, holds_begun = 0;
  int     hold_left = 0;

  midpoint_ellipse_points dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_plus(out_x_plus), .out_x_minus(out_x_minus),
    .out_y_plus(out_y_plus), .out_y_minus(out_y_minus),
    .out_region(out_region), .out_last_point(out_last_point),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit trace_step(input logic restart, output point_t pt);
    logic [63:0] rx2, ry2, a, b;
    logic signed [63:0] cx, cy, ox, oy;
    logic last;
    rx2 = 64'(cfg_rx) * 64'(cfg_rx);
    ry2 = 64'(cfg_ry) * 64'(cfg_ry);
    pt = '0;
    if (restart) begin
      ell_x = '0;
      ell_y = OFF_BITS'(cfg_ry);
      ell_sx = '0;
      ell_sy = SLOPE_BITS'(2 * rx2 * 64'(cfg_ry));
      ell_dec = DEC_BITS'(4 * ry2 - 4 * rx2 * 64'(cfg_ry) + rx2);
      ell_r2 = 1'b0;
      ell_active = 1'b1;
    end
    if (!ell_active) return 1'b0;
    if (!ell_r2 && !(ell_sx < ell_sy)) begin
      oy = 64'(ell_y);
      a = 2 * 64'(ell_x) + 1;
      b = oy - 1;
      ell_r2 = 1'b1;
      ell_dec = DEC_BITS'(ry2 * a * a + 4 * rx2 * (b * b) - 4 * rx2 * ry2);
    end
    ox = 64'(ell_x);
    oy = 64'(ell_y);
    cx = 64'(cfg_cx);
    cy = 64'(cfg_cy);
    last = ell_r2 && oy == 0;
    pt.x_plus = OUT_BITS'(cx + ox);
    pt.x_minus = OUT_BITS'(cx - ox);
    pt.y_plus = OUT_BITS'(cy + oy);
    pt.y_minus = OUT_BITS'(cy - oy);
    pt.region = ell_r2;
    pt.last_point = last;
    if (!ell_r2) begin
      ell_x = ell_x + 1'b1;
      ell_sx = ell_sx + SLOPE_BITS'(2 * ry2);
      if (ell_dec[DEC_BITS-1]) begin
        ell_dec = DEC_BITS'(64'(ell_dec) + 4 * (64'(ell_sx) + ry2));
      end else begin
        ell_y = ell_y - OFF_BITS'(1);
        ell_sy = ell_sy - SLOPE_BITS'(2 * rx2);
        ell_dec = DEC_BITS'(64'(ell_dec) + 4 * (64'(ell_sx) - 64'(ell_sy) + ry2));
      end
    end else begin
      ell_y = ell_y - OFF_BITS'(1);
      ell_sy = ell_sy - SLOPE_BITS'(2 * rx2);
      if (!ell_dec[DEC_BITS-1] && ell_dec != '0) begin
        ell_dec = DEC_BITS'(64'(ell_dec) + 4 * (rx2 - 64'(ell_sy)));
      end else begin
        ell_x = ell_x + 1'b1;
        ell_sx = ell_sx + SLOPE_BITS'(2 * ry2);
        ell_dec = DEC_BITS'(64'(ell_dec) + 4 * (64'(ell_sx) - 64'(ell_sy) + rx2));
      end
    end
    if (last) ell_active = 1'b0;
    return 1'b1;
  endfunction

  // sender: predict on accept, hold a stalled item, advance otherwise
  always @(posedge clk) begin
    point_t pt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_restart <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (trace_step(in_restart, pt)) begin
          expected_points.push_back(pt);
          points_made++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (step_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_restart <= step_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_begun != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      holds_begun <= holds_begun + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("point item with none expected");
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (out_x_plus !== want.x_plus) begin
          $error("x_plus expected %0d got %0d", want.x_plus, out_x_plus);
          mismatches++;
        end
        if (out_x_minus !== want.x_minus) begin
          $error("x_minus expected %0d got %0d", want.x_minus, out_x_minus);
          mismatches++;
        end
        if (out_y_plus !== want.y_plus) begin
          $error("y_plus expected %0d got %0d", want.y_plus, out_y_plus);
          mismatches++;
        end
        if (out_y_minus !== want.y_minus) begin
          $error("y_minus expected %0d got %0d", want.y_minus, out_y_minus);
          mismatches++;
        end
        if (out_region !== want.region) begin
          $error("region expected %0d got %0d", want.region, out_region);
          mismatches++;
        end
        if (out_last_point !== want.last_point) begin
          $error("last_point expected %0d got %0d", want.last_point, out_last_point);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(4 * idx);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CENTER_X: cfg_cx = data[COORD_BITS-1:0];
      REG_CENTER_Y: cfg_cy = data[COORD_BITS-1:0];
      REG_RADIUS_X: cfg_rx = data[RAD_BITS-1:0];
      REG_RADIUS_Y: cfg_ry = data[RAD_BITS-1:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_ellipse(input int cx, input int cy, input int rx, input int ry);
    logic [DATA_BITS-1:0] junk;
    junk = $urandom_range(1) ? DATA_BITS'($urandom) : '0;
    write_reg(REG_CENTER_X, (junk << COORD_BITS) | (DATA_BITS'(cx) & 32'h7ff));
    write_reg(REG_CENTER_Y, (junk << COORD_BITS) | (DATA_BITS'(cy) & 32'h7ff));
    write_reg(REG_RADIUS_X, (junk << RAD_BITS) | (DATA_BITS'(rx) & 32'h3ff));
    write_reg(REG_RADIUS_Y, (junk << RAD_BITS) | (DATA_BITS'(ry) & 32'h3ff));
  endtask

  task automatic push_items(input int restarts, input int advances);
    repeat (restarts) step_items.push_back(1'b1);
    repeat (advances) step_items.push_back(1'b0);
  endtask

  task automatic queue_outline(input bit full_length);
    int n, kind;
    kind = full_length ? 99 : int'($urandom_range(99));
    n = int'(cfg_rx) + int'(cfg_ry) + 2;
    if (n > 60 && !full_length) n = $urandom_range(1, 60);
    if (kind < 15) begin
      repeat ($urandom_range(1, 8)) step_items.push_back(1'($urandom_range(1)));
    end else begin
      if (kind < 30) n = $urandom_range(0, n);
      else n += $urandom_range(0, 2);
      push_items(1, n);
    end
  endtask

  task automatic settle();
    while (step_items.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int pick_center();
    case ($urandom_range(9))
      0: return -1024;
      1: return 1023;
      default: return int'($urandom_range(2047)) - 1024;
    endcase
  endfunction

  function automatic int pick_radius();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 8) return 1023;
    if (r < 20) return $urandom_range(1023);
    return $urandom_range(24);
  endfunction

  task automatic run_phase(input int send_pct, input int recv_pct, input int goal,
                           input bit squeeze);
    int target;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    target = points_made + goal;
    while (points_made < target) begin
      program_ellipse(pick_center(), pick_center(), pick_radius(), pick_radius());
      if (squeeze) begin
        program_ellipse(pick_center(), pick_center(), 20, 30);
        holds_asked++;
        squeeze = 1'b0;
        push_items(1, 40);
      end
      repeat ($urandom_range(1, 4)) queue_outline(1'b0);
      settle();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle advance, zero radii, advance past the end
    push_items(0, 1);
    push_items(1, 1);
    settle();
    // radius_x zero goes straight to region two
    program_ellipse(-1024, 1023, 0, 3);
    push_items(1, 5);
    settle();
    // small outline, center moved mid-outline, restarts mid-outline
    program_ellipse(1023, -1024, 3, 2);
    push_items(1, 3);
    settle();
    write_reg(REG_CENTER_X, 32'd5);
    push_items(0, 4);
    push_items(1, 2);
    push_items(1, 3);
    settle();

    run_phase(17, 73, 120, 1'b1);
    run_phase(73, 17, 120, 1'b0);
    run_phase(0, 0, 120, 1'b0);
    program_ellipse(1023, -1024, 200, 150);
    queue_outline(1'b1);
    settle();

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
